>>> design/vhbc_pkg.sv
package vhbc_pkg;

	// Chunk geometry. Cell address is {x, y, z}, so every dimension is a
	// power of two that fills its field.
	localparam int CHUNK_X = 16;
	localparam int CHUNK_Y = 64;
	localparam int CHUNK_Z = 16;
	localparam int VERTS_PER_BLOCK = 36;

	localparam int CX_W = 4;
	localparam int CY_W = 6;
	localparam int CZ_W = 4;
	localparam int VX_W = CX_W + 1;
	localparam int VY_W = CY_W + 1;
	localparam int VZ_W = CZ_W + 1;
	localparam int VIDX_W = 6;

	// Occupancy map is stored as rows of 64 cells: row = {x, y[5:2]},
	// bit = {y[1:0], z}.
	localparam int ROW_CELLS = 64;
	localparam int BIT_W = 6;
	localparam int MAP_ROWS = (CHUNK_X * CHUNK_Y * CHUNK_Z) / ROW_CELLS;
	localparam int ROW_W = 8;

	localparam int UPC_W = 4;

	typedef logic [UPC_W-1:0] upc_t;
	typedef logic [ROW_W-1:0] row_addr_t;
	typedef logic [ROW_CELLS-1:0] row_data_t;

	typedef enum logic [2:0] {
		SEL_SELF,
		SEL_XP,
		SEL_XM,
		SEL_YP,
		SEL_YM,
		SEL_ZP,
		SEL_ZM
	} sel_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_END,
		JMP_END_IF_HIDDEN,
		JMP_LOOP_EMIT
	} jump_t;

	typedef struct packed {
		logic rd;
		sel_t sel;
		logic chk;
		logic wr;
		logic emit;
		jump_t jmp;
	} uword_t;

	typedef struct packed {
		logic hidden;
		logic last_vtx;
	} seq_stat_t;

	localparam uword_t UWORD_NOP = '{rd: 1'b0, sel: SEL_SELF, chk: 1'b0, wr: 1'b0,
		emit: 1'b0, jmp: JMP_END};

	// Program entry points.
	localparam upc_t UPC_INS_RD = 4'd0;
	localparam upc_t UPC_INS_WR = 4'd1;
	localparam upc_t UPC_T_XP = 4'd2;
	localparam upc_t UPC_T_XM = 4'd3;
	localparam upc_t UPC_T_YP = 4'd4;
	localparam upc_t UPC_T_YM = 4'd5;
	localparam upc_t UPC_T_ZP = 4'd6;
	localparam upc_t UPC_T_ZM = 4'd7;
	localparam upc_t UPC_T_DEC = 4'd8;
	localparam upc_t UPC_T_EMIT = 4'd9;

	function automatic uword_t ucode(input upc_t upc);
		uword_t w;
		w = UWORD_NOP;
		unique case (upc)
			UPC_INS_RD: w = '{rd: 1'b1, sel: SEL_SELF, chk: 1'b0, wr: 1'b0,
				emit: 1'b0, jmp: JMP_NEXT};
			UPC_INS_WR: w = '{rd: 1'b0, sel: SEL_SELF, chk: 1'b0, wr: 1'b1,
				emit: 1'b0, jmp: JMP_END};
			UPC_T_XP: w = '{rd: 1'b1, sel: SEL_XP, chk: 1'b0, wr: 1'b0,
				emit: 1'b0, jmp: JMP_NEXT};
			UPC_T_XM: w = '{rd: 1'b1, sel: SEL_XM, chk: 1'b1, wr: 1'b0,
				emit: 1'b0, jmp: JMP_NEXT};
			UPC_T_YP: w = '{rd: 1'b1, sel: SEL_YP, chk: 1'b1, wr: 1'b0,
				emit: 1'b0, jmp: JMP_NEXT};
			UPC_T_YM: w = '{rd: 1'b1, sel: SEL_YM, chk: 1'b1, wr: 1'b0,
				emit: 1'b0, jmp: JMP_NEXT};
			UPC_T_ZP: w = '{rd: 1'b1, sel: SEL_ZP, chk: 1'b1, wr: 1'b0,
				emit: 1'b0, jmp: JMP_NEXT};
			UPC_T_ZM: w = '{rd: 1'b1, sel: SEL_ZM, chk: 1'b1, wr: 1'b0,
				emit: 1'b0, jmp: JMP_NEXT};
			UPC_T_DEC: w = '{rd: 1'b0, sel: SEL_SELF, chk: 1'b1, wr: 1'b0,
				emit: 1'b0, jmp: JMP_END_IF_HIDDEN};
			UPC_T_EMIT: w = '{rd: 1'b0, sel: SEL_SELF, chk: 1'b0, wr: 1'b0,
				emit: 1'b1, jmp: JMP_LOOP_EMIT};
			default: w = UWORD_NOP;
		endcase
		return w;
	endfunction

	// Corner offsets {x, y, z} of the cube's twelve triangles:
	// top, bottom, front, back, left, right.
	function automatic logic [2:0] corner(input logic [VIDX_W-1:0] idx);
		logic [2:0] c;
		c = 3'b000;
		unique case (idx)
			6'd0: c = 3'b010;
			6'd1: c = 3'b110;
			6'd2: c = 3'b111;
			6'd3: c = 3'b010;
			6'd4: c = 3'b111;
			6'd5: c = 3'b011;
			6'd6: c = 3'b001;
			6'd7: c = 3'b101;
			6'd8: c = 3'b100;
			6'd9: c = 3'b001;
			6'd10: c = 3'b100;
			6'd11: c = 3'b000;
			6'd12: c = 3'b001;
			6'd13: c = 3'b011;
			6'd14: c = 3'b111;
			6'd15: c = 3'b001;
			6'd16: c = 3'b111;
			6'd17: c = 3'b101;
			6'd18: c = 3'b100;
			6'd19: c = 3'b110;
			6'd20: c = 3'b010;
			6'd21: c = 3'b100;
			6'd22: c = 3'b010;
			6'd23: c = 3'b000;
			6'd24: c = 3'b000;
			6'd25: c = 3'b010;
			6'd26: c = 3'b011;
			6'd27: c = 3'b000;
			6'd28: c = 3'b011;
			6'd29: c = 3'b001;
			6'd30: c = 3'b101;
			6'd31: c = 3'b111;
			6'd32: c = 3'b110;
			6'd33: c = 3'b101;
			6'd34: c = 3'b110;
			6'd35: c = 3'b100;
			default: c = 3'b000;
		endcase
		return c;
	endfunction

endpackage

>>> design/voxel_hidden_block_cull.sv
// Six-neighbour hidden block cull for one 16 x 64 x 16 voxel chunk.
//
// Command channel: present opcode and cell_x/y/z with start high; the item is
// transferred at the rising edge where start is high and busy is low. busy then
// stays high while the item's microprogram runs.
//   opcode 0 (insert): mark the cell occupied (row read, then write); no result.
//   opcode 1 (test): read the six face neighbours one per cycle through the
//   single read port of the occupancy store. If all six are occupied the
//   cell is hidden and nothing is emitted. Otherwise 36 vertices follow, one
//   per cycle.
// Results: vert_x/y/z and last_vertex are valid for one cycle each, marked by
// vert_valid; last_vertex flags the 36th. The receiver cannot stall, so every
// strobed vertex is a transfer. The first vertex follows the six neighbour
// reads, the hidden decision and the output register; a new item may be
// transferred in the cycle showing the last. The one read port and one vertex
// per cycle set the rate, and a new item is taken only once busy is low.
// Reset: arst_n clears the sequencer, the output strobe and the store's 256 row
// valid bits, so the map reads empty at once; there is no clearing pass.
module voxel_hidden_block_cull (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic opcode,
	input logic [vhbc_pkg::CX_W-1:0] cell_x,
	input logic [vhbc_pkg::CY_W-1:0] cell_y,
	input logic [vhbc_pkg::CZ_W-1:0] cell_z,
	output logic vert_valid,
	output logic [vhbc_pkg::VX_W-1:0] vert_x,
	output logic [vhbc_pkg::VY_W-1:0] vert_y,
	output logic [vhbc_pkg::VZ_W-1:0] vert_z,
	output logic last_vertex
);

	logic accept;
	vhbc_pkg::uword_t ctl;
	vhbc_pkg::seq_stat_t stat;

	// Captured command
	logic [vhbc_pkg::CX_W-1:0] cx_q;
	logic [vhbc_pkg::CY_W-1:0] cy_q;
	logic [vhbc_pkg::CZ_W-1:0] cz_q;

	// Neighbour address generation
	logic [vhbc_pkg::VX_W-1:0] nx;
	logic [vhbc_pkg::VY_W-1:0] ny;
	logic [vhbc_pkg::VZ_W-1:0] nz;
	logic n_inside;
	vhbc_pkg::row_addr_t n_row;
	logic [vhbc_pkg::BIT_W-1:0] n_bit;

	// Lookup results arrive in the cycle after the read
	logic nb_in_q;
	logic [vhbc_pkg::BIT_W-1:0] nb_bit_q;
	vhbc_pkg::row_data_t rd_data;
	logic rd_valid;
	vhbc_pkg::row_data_t row_now;
	logic occ;
	logic all_occ_q;
	vhbc_pkg::row_data_t wr_data;

	// Emission
	logic [vhbc_pkg::VIDX_W-1:0] vidx_q;
	logic last_vtx;
	logic [2:0] off;
	logic vert_valid_q;
	logic [vhbc_pkg::VX_W-1:0] vert_x_q;
	logic [vhbc_pkg::VY_W-1:0] vert_y_q;
	logic [vhbc_pkg::VZ_W-1:0] vert_z_q;
	logic last_vertex_q;

	assign accept = start && !busy;

	vhbc_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.opcode(opcode),
		.stat(stat),
		.busy(busy),
		.ctl(ctl)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= cell_x;
			cy_q <= cell_y;
			cz_q <= cell_z;
		end
	end

	// Offset the captured cell toward the selected face. A step below zero wraps
	// to the top of the wider code and so fails the bounds check, like one above.
	always_comb begin
		nx = {1'b0, cx_q};
		ny = {1'b0, cy_q};
		nz = {1'b0, cz_q};
		unique case (ctl.sel)
			vhbc_pkg::SEL_SELF: ;
			vhbc_pkg::SEL_XP: nx = {1'b0, cx_q} + 1'b1;
			vhbc_pkg::SEL_XM: nx = {1'b0, cx_q} - 1'b1;
			vhbc_pkg::SEL_YP: ny = {1'b0, cy_q} + 1'b1;
			vhbc_pkg::SEL_YM: ny = {1'b0, cy_q} - 1'b1;
			vhbc_pkg::SEL_ZP: nz = {1'b0, cz_q} + 1'b1;
			vhbc_pkg::SEL_ZM: nz = {1'b0, cz_q} - 1'b1;
			default: ;
		endcase
		n_inside = (nx < vhbc_pkg::VX_W'(vhbc_pkg::CHUNK_X))
			&& (ny < vhbc_pkg::VY_W'(vhbc_pkg::CHUNK_Y))
			&& (nz < vhbc_pkg::VZ_W'(vhbc_pkg::CHUNK_Z));
		n_row = {nx[vhbc_pkg::CX_W-1:0], ny[vhbc_pkg::CY_W-1:2]};
		n_bit = {ny[1:0], nz[vhbc_pkg::CZ_W-1:0]};
	end

	// Insert is read-modify-write: OR the cell's bit into the row read last step.
	assign row_now = rd_valid ? rd_data : '0;
	assign wr_data = row_now | (vhbc_pkg::row_data_t'(1) << n_bit);

	vhbc_occ_mem u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(ctl.rd),
		.rd_row(n_row),
		.wr_en(ctl.wr && n_inside),
		.wr_row(n_row),
		.wr_data(wr_data),
		.rd_data(rd_data),
		.rd_valid(rd_valid)
	);

	// A neighbour outside the chunk counts as empty.
	assign occ = nb_in_q && row_now[nb_bit_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_in_q <= 1'b0;
			all_occ_q <= 1'b0;
		end else begin
			if (ctl.rd) begin
				nb_in_q <= n_inside;
			end
			if (accept) begin
				all_occ_q <= 1'b1;
			end else if (ctl.chk) begin
				all_occ_q <= all_occ_q && occ;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			nb_bit_q <= n_bit;
		end
	end

	assign last_vtx = (vidx_q == vhbc_pkg::VIDX_W'(vhbc_pkg::VERTS_PER_BLOCK - 1));
	assign stat.hidden = all_occ_q && occ;
	assign stat.last_vtx = last_vtx;
	assign off = vhbc_pkg::corner(vidx_q);

	// Walk the corner table one vertex per cycle; the index is back at zero
	// after the run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vidx_q <= '0;
			vert_valid_q <= 1'b0;
		end else begin
			vert_valid_q <= ctl.emit;
			if (ctl.emit) begin
				vidx_q <= last_vtx ? '0 : vidx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			vert_x_q <= {1'b0, cx_q} + vhbc_pkg::VX_W'(off[2]);
			vert_y_q <= {1'b0, cy_q} + vhbc_pkg::VY_W'(off[1]);
			vert_z_q <= {1'b0, cz_q} + vhbc_pkg::VZ_W'(off[0]);
			last_vertex_q <= last_vtx;
		end
	end

	assign vert_valid = vert_valid_q;
	assign vert_x = vert_x_q;
	assign vert_y = vert_y_q;
	assign vert_z = vert_z_q;
	assign last_vertex = last_vertex_q;

endmodule

>>> design/vhbc_seq.sv
module vhbc_seq (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic opcode,
	input vhbc_pkg::seq_stat_t stat,
	output logic busy,
	output vhbc_pkg::uword_t ctl
);

	logic busy_q;
	vhbc_pkg::upc_t upc_q;
	vhbc_pkg::uword_t word;

	assign word = vhbc_pkg::ucode(upc_q);
	assign busy = busy_q;
	assign ctl = busy_q ? word : vhbc_pkg::UWORD_NOP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q <= vhbc_pkg::UPC_INS_RD;
		end else if (!busy_q) begin
			if (accept) begin
				busy_q <= 1'b1;
				upc_q <= opcode ? vhbc_pkg::UPC_T_XP : vhbc_pkg::UPC_INS_RD;
			end
		end else begin
			unique case (word.jmp)
				vhbc_pkg::JMP_NEXT: upc_q <= upc_q + 1'b1;
				vhbc_pkg::JMP_END: busy_q <= 1'b0;
				vhbc_pkg::JMP_END_IF_HIDDEN: begin
					if (stat.hidden) begin
						busy_q <= 1'b0;
					end else begin
						upc_q <= upc_q + 1'b1;
					end
				end
				vhbc_pkg::JMP_LOOP_EMIT: begin
					if (stat.last_vtx) begin
						busy_q <= 1'b0;
					end
				end
				default: busy_q <= 1'b0;
			endcase
		end
	end

endmodule

>>> design/vhbc_occ_mem.sv
module vhbc_occ_mem (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input vhbc_pkg::row_addr_t rd_row,
	input logic wr_en,
	input vhbc_pkg::row_addr_t wr_row,
	input vhbc_pkg::row_data_t wr_data,
	output vhbc_pkg::row_data_t rd_data,
	output logic rd_valid
);

	vhbc_pkg::row_data_t mem [vhbc_pkg::MAP_ROWS];
	logic [vhbc_pkg::MAP_ROWS-1:0] row_valid_q;
	vhbc_pkg::row_data_t rd_data_q;
	logic rd_valid_q;

	assign rd_data = rd_data_q;
	assign rd_valid = rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_row];
		end
	end

	// Row valid bits stand in for clearing the array: a row never written reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= row_valid_q[rd_row];
			end
		end
	end

endmodule

>>> design/vhbc_checker.sv
module vhbc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic vert_valid,
	input logic last_vertex
);

	// Every transferred item runs at least one step.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transferred item did not raise busy");

	// Vertices before the last are shown while the item is still running.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vert_valid && !last_vertex |-> busy)
		else $error("vertex shown with block idle");

	// A run of vertices is unbroken up to its last one.
	a_run_contig: assert property (@(posedge clk) disable iff (!arst_n)
		vert_valid && !last_vertex |=> vert_valid)
		else $error("gap inside a vertex run");

	// The last vertex closes the run.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		vert_valid && last_vertex |=> !vert_valid)
		else $error("vertex follows the last one");

	// A run never opens on its last vertex.
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vert_valid) |-> !last_vertex)
		else $error("run opened with last vertex");

endmodule

bind voxel_hidden_block_cull vhbc_checker u_vhbc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.vert_valid(vert_valid),
	.last_vertex(last_vertex)
);

>>> test/vhbc_tb_pkg.sv
`timescale 1ns / 1ps

package vhbc_tb_pkg;

	// Command codes on the opcode port.
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_TEST = 1'b1
	} cell_op_e;

endpackage

>>> test/vhbc_cull_checker.sv
`timescale 1ns / 1ps

module vhbc_cull_checker
	import vhbc_pkg::*;
	import vhbc_tb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic [CX_W-1:0] cell_x,
	input logic [CY_W-1:0] cell_y,
	input logic [CZ_W-1:0] cell_z,
	input logic vert_valid,
	input logic [VX_W-1:0] vert_x,
	input logic [VY_W-1:0] vert_y,
	input logic [VZ_W-1:0] vert_z,
	input logic last_vertex,
	output int mismatches,
	output int pending_vertices
);

	localparam int MAP_CELLS = CHUNK_X * CHUNK_Y * CHUNK_Z;

	typedef struct packed {
		logic [VX_W-1:0] x;
		logic [VY_W-1:0] y;
		logic [VZ_W-1:0] z;
		logic last;
	} cube_vertex_t;

	// Corner offsets {x, y, z}, two triangles per face.
	localparam logic [2:0] CUBE_CORNERS [VERTS_PER_BLOCK] = '{
		3'b010, 3'b110, 3'b111, 3'b010, 3'b111, 3'b011,	// top
		3'b001, 3'b101, 3'b100, 3'b001, 3'b100, 3'b000,	// bottom
		3'b001, 3'b011, 3'b111, 3'b001, 3'b111, 3'b101,	// front
		3'b100, 3'b110, 3'b010, 3'b100, 3'b010, 3'b000,	// back
		3'b000, 3'b010, 3'b011, 3'b000, 3'b011, 3'b001,	// left
		3'b101, 3'b111, 3'b110, 3'b101, 3'b110, 3'b100	// right
	};

	bit [MAP_CELLS-1:0] occupied;
	cube_vertex_t cube_vertices_due[$];
	int error_count;

	function automatic int cell_index(input int x, input int y, input int z);
		return (x * CHUNK_Y + y) * CHUNK_Z + z;
	endfunction

	// Cells outside the chunk read as empty.
	function automatic bit cell_filled(input int x, input int y, input int z);
		if (x < 0 || x >= CHUNK_X || y < 0 || y >= CHUNK_Y || z < 0 || z >= CHUNK_Z)
			return 1'b0;
		return occupied[cell_index(x, y, z)];
	endfunction

	function automatic bit cell_buried(input int x, input int y, input int z);
		return cell_filled(x + 1, y, z) && cell_filled(x - 1, y, z) &&
			cell_filled(x, y + 1, z) && cell_filled(x, y - 1, z) &&
			cell_filled(x, y, z + 1) && cell_filled(x, y, z - 1);
	endfunction

	task automatic queue_cube(input int x, input int y, input int z);
		cube_vertex_t v;
		for (int i = 0; i < VERTS_PER_BLOCK; i++) begin
			v.x = VX_W'(x + CUBE_CORNERS[i][2]);
			v.y = VY_W'(y + CUBE_CORNERS[i][1]);
			v.z = VZ_W'(z + CUBE_CORNERS[i][0]);
			v.last = (i == VERTS_PER_BLOCK - 1);
			cube_vertices_due.push_back(v);
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t ns: vertex mismatch: %s", $time, what);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cube_vertex_t want;
		int cx;
		int cy;
		int cz;
		if (!arst_n) begin
			occupied = '0;
			cube_vertices_due.delete();
		end else begin
			// Results first: anything strobed this edge belongs to an earlier test.
			if (vert_valid) begin
				if (cube_vertices_due.size() == 0) begin
					report_mismatch($sformatf("(%0d,%0d,%0d) last=%0b with none due",
						vert_x, vert_y, vert_z, last_vertex));
				end else begin
					want = cube_vertices_due.pop_front();
					if (vert_x !== want.x)
						report_mismatch($sformatf("vert_x %0d, want %0d", vert_x, want.x));
					if (vert_y !== want.y)
						report_mismatch($sformatf("vert_y %0d, want %0d", vert_y, want.y));
					if (vert_z !== want.z)
						report_mismatch($sformatf("vert_z %0d, want %0d", vert_z, want.z));
					if (last_vertex !== want.last)
						report_mismatch($sformatf("last_vertex %0b, want %0b",
							last_vertex, want.last));
				end
			end
			if (start && !busy) begin
				cx = int'(cell_x);
				cy = int'(cell_y);
				cz = int'(cell_z);
				if (opcode == OP_INSERT)
					occupied[cell_index(cx, cy, cz)] = 1'b1;
				else if (!cell_buried(cx, cy, cz))
					queue_cube(cx, cy, cz);
			end
		end
		mismatches <= error_count;
		pending_vertices <= cube_vertices_due.size();
	end

endmodule

>>> test/tb_voxel_hidden_block_cull.sv
`timescale 1ns / 1ps

module tb_voxel_hidden_block_cull;
	import vhbc_pkg::*;
	import vhbc_tb_pkg::*;

	// Total items to send, directed part included.
	localparam int ITEM_TARGET = 360;
	// Longest correct quiet stretch is the longer of a sender gap and a test's busy run before its first vertex.
	localparam int WATCHDOG_LIMIT = 1000;
	// Longer than a visible test keeps the block busy past its transfer.
	localparam int DRAIN_CYCLES = 60;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic opcode;
	logic [CX_W-1:0] cell_x;
	logic [CY_W-1:0] cell_y;
	logic [CZ_W-1:0] cell_z;
	logic vert_valid;
	logic [VX_W-1:0] vert_x;
	logic [VY_W-1:0] vert_y;
	logic [VZ_W-1:0] vert_z;
	logic last_vertex;

	int mismatches;
	int pending_vertices;
	int items_sent;
	int burst_left;
	int quiet_cycles;

	voxel_hidden_block_cull i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.cell_z(cell_z),
		.vert_valid(vert_valid),
		.vert_x(vert_x),
		.vert_y(vert_y),
		.vert_z(vert_z),
		.last_vertex(last_vertex)
	);

	vhbc_cull_checker i_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.cell_z(cell_z),
		.vert_valid(vert_valid),
		.vert_x(vert_x),
		.vert_y(vert_y),
		.vert_z(vert_z),
		.last_vertex(last_vertex),
		.mismatches(mismatches),
		.pending_vertices(pending_vertices)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: count edges with neither a command nor a vertex transfer.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || vert_valid) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("voxel_hidden_block_cull verification failed");
				$finish;
			end
		end
	end

	// Send one command. Called just after a falling edge; returns just after the
	// falling edge that follows its transfer. Start stays high across a burst,
	// so back-to-back items only swap the fields.
	task automatic push_cell(input cell_op_e op, input int x, input int y, input int z);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				// Drop start and wiggle the fields so idle values get exercised too.
				start = 1'b0;
				opcode = 1'($urandom_range(0, 1));
				cell_x = CX_W'($urandom);
				cell_y = CY_W'($urandom);
				cell_z = CZ_W'($urandom);
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		start = 1'b1;
		opcode = op;
		cell_x = x[CX_W-1:0];
		cell_y = y[CY_W-1:0];
		cell_z = z[CZ_W-1:0];
		// Hold until an edge finds the block free: that edge is the transfer.
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		items_sent++;
	endtask

	// Fill the six face neighbours of a cell in a rotated order, then test it.
	// Optionally leave one neighbour out (visible unless filled earlier) or fill
	// the cell itself (must not change the outcome). Neighbours off the chunk are skipped.
	task automatic bury_and_test(input int x, input int y, input int z,
			input bit leave_gap, input bit fill_self);
		int first;
		int skip;
		int face;
		int nx;
		int ny;
		int nz;
		first = $urandom_range(0, 5);
		skip = leave_gap ? $urandom_range(0, 5) : 6;
		for (int k = 0; k < 6; k++) begin
			face = (first + k) % 6;
			nx = x;
			ny = y;
			nz = z;
			case (face)
				0: nx = x + 1;
				1: nx = x - 1;
				2: ny = y + 1;
				3: ny = y - 1;
				4: nz = z + 1;
				default: nz = z - 1;
			endcase
			if (face != skip && nx >= 0 && nx < CHUNK_X && ny >= 0 && ny < CHUNK_Y &&
					nz >= 0 && nz < CHUNK_Z)
				push_cell(OP_INSERT, nx, ny, nz);
		end
		if (fill_self)
			push_cell(OP_INSERT, x, y, z);
		push_cell(OP_TEST, x, y, z);
	endtask

	initial begin
		int x;
		int y;
		int z;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_INSERT;
		cell_x = '0;
		cell_y = '0;
		cell_z = '0;
		items_sent = 0;
		burst_left = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty map at the low corner.
		push_cell(OP_TEST, 0, 0, 0);
		// Fully enclosed cell that was never inserted itself: hidden.
		bury_and_test(5, 10, 7, 1'b0, 1'b0);
		// Insert it twice, then test again: still hidden, repeat is harmless.
		push_cell(OP_INSERT, 5, 10, 7);
		push_cell(OP_INSERT, 5, 10, 7);
		push_cell(OP_TEST, 5, 10, 7);
		// On the chunk face: the missing outside neighbour keeps it visible.
		bury_and_test(0, 20, 3, 1'b0, 1'b1);
		// Largest field values.
		push_cell(OP_INSERT, CHUNK_X - 1, CHUNK_Y - 1, CHUNK_Z - 1);
		push_cell(OP_TEST, CHUNK_X - 1, CHUNK_Y - 1, CHUNK_Z - 1);
		// One neighbour short of enclosed: visible.
		bury_and_test(9, 30, 12, 1'b1, 1'b0);

		// Random: mostly enclosure sequences, the rest loose inserts and tests.
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					if ($urandom_range(0, 3) == 0) begin
						x = $urandom_range(0, CHUNK_X - 1);
						y = $urandom_range(0, CHUNK_Y - 1);
						z = $urandom_range(0, CHUNK_Z - 1);
					end else begin
						x = $urandom_range(1, CHUNK_X - 2);
						y = $urandom_range(1, CHUNK_Y - 2);
						z = $urandom_range(1, CHUNK_Z - 2);
					end
					bury_and_test(x, y, z, $urandom_range(0, 3) == 0,
						$urandom_range(0, 1) == 1);
				end
				5, 6: push_cell(OP_TEST, $urandom_range(0, CHUNK_X - 1),
					$urandom_range(0, CHUNK_Y - 1), $urandom_range(0, CHUNK_Z - 1));
				7, 8: push_cell(OP_INSERT, $urandom_range(0, CHUNK_X - 1),
					$urandom_range(0, CHUNK_Y - 1), $urandom_range(0, CHUNK_Z - 1));
				default: begin
					// Test a cell pinned to one face of the chunk.
					x = $urandom_range(0, CHUNK_X - 1);
					y = $urandom_range(0, CHUNK_Y - 1);
					z = $urandom_range(0, CHUNK_Z - 1);
					case ($urandom_range(0, 2))
						0: x = $urandom_range(0, 1) ? CHUNK_X - 1 : 0;
						1: y = $urandom_range(0, 1) ? CHUNK_Y - 1 : 0;
						default: z = $urandom_range(0, 1) ? CHUNK_Z - 1 : 0;
					endcase
					push_cell(OP_TEST, x, y, z);
				end
			endcase
		end

		// Drain: release start, wait out every due vertex, then watch for strays.
		start = 1'b0;
		while (pending_vertices != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("voxel_hidden_block_cull verification clean");
		else
			$display("voxel_hidden_block_cull verification failed");
		$finish;
	end

endmodule

>>> files.f
design/vhbc_pkg.sv
design/vhbc_seq.sv
design/vhbc_occ_mem.sv
design/voxel_hidden_block_cull.sv
design/vhbc_checker.sv
test/vhbc_tb_pkg.sv
test/vhbc_cull_checker.sv
test/tb_voxel_hidden_block_cull.sv
